>>> design/arpc_pkg.sv
// Package for the ARP cache table with time-to-live aging.
// Holds the entry record, the configuration bundle and the operation, status and result codes.
// It depends on nothing else and every other file imports it.
package arpc_pkg;

	localparam int OUT_IDX_W = 5;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_ALLOC  = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [1:0] ST_FREE     = 2'd0;
	localparam logic [1:0] ST_PENDING  = 2'd1;
	localparam logic [1:0] ST_RESOLVED = 2'd2;

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_STORED = 3'd1;
	localparam logic [2:0] KIND_FULL   = 3'd2;
	localparam logic [2:0] KIND_RETRY  = 3'd3;
	localparam logic [2:0] KIND_DROP   = 3'd4;
	localparam logic [2:0] KIND_TICK   = 3'd5;

	localparam logic [0:0] REG_TIMEOUT = 1'b0;
	localparam logic [0:0] REG_RETRY   = 1'b1;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [15:0] ttl;
		logic [3:0]  retries;
	} entry_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [3:0]  retry_limit;
	} cfg_t;

endpackage

>>> design/arp_cache_table_with_aging_top.sv
// Channel  | Direction | Handshake                 | Contents
// s_*      | in        | s_tvalid / s_tready       | operation in s_tuser, addresses in s_tdata
// m_*      | out       | m_tvalid / m_tready       | result kind in m_tuser, fields in m_tdata
// APB      | in        | psel, penable, pready     | time-to-live reload and retry limit
//
// One operation is worked at a time; the entry memory is read at most once per entry in index order.
// A lookup hit or a claim ends the scan at the matching or free entry; a miss, a full
// reply or a tick scans every entry. The input is ready again once the result beat is
// registered. A busy result register stalls the scan.
// Reset frees every entry at once.
// Depends on arpc_pkg, arpc_cfg_regs, arpc_entry_mem and arpc_scan_ctrl.
module arp_cache_table_with_aging_top #(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32], tick_delay[95:80]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // hit[0], is_resolved[1], entry_index[6:2], ip_out[38:7],
	                               // mac_out[86:39], zero[87]
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import arpc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	cfg_t             cfg;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	arpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arpc_entry_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	arpc_scan_ctrl #(.ENTRIES(ENTRIES)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

>>> design/arpc_entry_mem.sv
// Synchronous entry memory with one write port and one registered read port.
// Stores one arpc_pkg::entry_t record per table entry; depends on arpc_pkg.
module arpc_entry_mem #(
	parameter int ENTRIES = 32
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(ENTRIES)-1:0]   waddr,
	input  arpc_pkg::entry_t             wdata,
	input  logic                         re,
	input  logic [$clog2(ENTRIES)-1:0]   raddr,
	output arpc_pkg::entry_t             rdata
);
	import arpc_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/arpc_cfg_regs.sv
// APB-style configuration registers: time-to-live reload value and retry limit.
// Depends on arpc_pkg for the configuration bundle and register indexes.
module arpc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output arpc_pkg::cfg_t     cfg
);
	import arpc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd600;
			cfg_q.retry_limit   <= 4'd4;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[15:0];
				REG_RETRY:   cfg_q.retry_limit   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
			REG_RETRY:   prdata = {28'd0, cfg_q.retry_limit};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

>>> design/arpc_scan_ctrl.sv
// Scan sequencer: walks the entry memory one entry a cycle unless a busy result stalls it;
// reads, modifies and writes back, and holds the result register. Status lives in flip-flops
// cleared by reset. Depends on arpc_pkg; drives the ports of arpc_entry_mem.
module arpc_scan_ctrl #(
	parameter int ENTRIES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arpc_pkg::cfg_t               cfg,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [95:0]                  s_tdata,
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [87:0]                  m_tdata,
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast,
	output logic                         mem_we,
	output logic [$clog2(ENTRIES)-1:0]   mem_waddr,
	output arpc_pkg::entry_t             mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(ENTRIES)-1:0]   mem_raddr,
	input  arpc_pkg::entry_t             mem_rdata
);
	import arpc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        op_q;
	logic [31:0]       ip_q;
	logic [47:0]       mac_q;
	logic [15:0]       delay_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              rd_pend_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [1:0]        status_q [ENTRIES];

	logic              out_valid_q;
	logic [2:0]        out_kind_q;
	logic              out_hit_q;
	logic              out_res_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [31:0]       out_ip_q;
	logic [47:0]       out_mac_q;
	logic              out_last_q;

	logic [1:0]        st;
	logic              live;
	logic              expire;
	logic              need_emit;
	logic              finish;
	logic              wr;
	logic              st_wr;
	logic [1:0]        st_new;
	entry_t            wentry;
	logic [2:0]        e_kind;
	logic              e_hit;
	logic              e_res;
	logic [31:0]       e_ip;
	logic [47:0]       e_mac;
	logic              e_last;
	logic              emit_ok;
	logic              stall;
	logic              proc;
	logic              finish_now;
	logic              advance;
	logic              emit;
	logic              accept;
	logic [OUT_IDX_W+IDX_W-1:0] idx_ext;

	assign emit_ok  = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign st       = status_q[idx_s1];
	assign live     = (st != ST_FREE);
	assign expire   = live && (mem_rdata.ttl <= delay_q);
	assign idx_ext  = {{OUT_IDX_W{1'b0}}, idx_s1};

	always_comb begin
		need_emit = 1'b0;
		finish    = 1'b0;
		wr        = 1'b0;
		st_wr     = 1'b0;
		st_new    = st;
		wentry    = mem_rdata;
		e_kind    = KIND_LOOKUP;
		e_hit     = 1'b0;
		e_res     = 1'b0;
		e_ip      = 32'd0;
		e_mac     = 48'd0;
		e_last    = 1'b1;
		if (state_q == S_FIN) begin
			unique case (op_q) inside
				OP_LOOKUP:          e_kind = KIND_LOOKUP;
				OP_INSERT, OP_ALLOC: e_kind = KIND_FULL;
				default:            e_kind = KIND_TICK;
			endcase
		end else begin
			unique case (op_q) inside
				OP_LOOKUP: begin
					if (live && (mem_rdata.ip == ip_q)) begin
						need_emit = 1'b1;
						finish    = 1'b1;
						e_hit     = 1'b1;
						e_res     = (st == ST_RESOLVED);
						e_ip      = mem_rdata.ip;
						e_mac     = mem_rdata.mac;
					end
				end
				OP_INSERT, OP_ALLOC: begin
					if (!live) begin
						need_emit      = 1'b1;
						finish         = 1'b1;
						wr             = 1'b1;
						st_wr          = 1'b1;
						st_new         = (op_q == OP_INSERT) ? ST_RESOLVED : ST_PENDING;
						wentry.ip      = ip_q;
						wentry.mac     = (op_q == OP_INSERT) ? mac_q : 48'd0;
						wentry.ttl     = cfg.timeout_ticks;
						wentry.retries = cfg.retry_limit;
						e_kind         = KIND_STORED;
						e_ip           = ip_q;
					end
				end
				default: begin
					e_ip   = mem_rdata.ip;
					e_last = 1'b0;
					if (live && !expire) begin
						wr         = 1'b1;
						wentry.ttl = mem_rdata.ttl - delay_q;
					end else if (expire && (st == ST_RESOLVED)) begin
						st_wr  = 1'b1;
						st_new = ST_FREE;
					end else if (expire) begin
						need_emit = 1'b1;
						if (mem_rdata.retries == 4'd0) begin
							st_wr  = 1'b1;
							st_new = ST_FREE;
							e_kind = KIND_DROP;
						end else begin
							wr             = 1'b1;
							wentry.ttl     = cfg.timeout_ticks;
							wentry.retries = mem_rdata.retries - 4'd1;
							e_kind         = KIND_RETRY;
						end
					end
				end
			endcase
		end
	end

	assign stall      = v_s1 && need_emit && !emit_ok;
	assign proc       = (state_q == S_SCAN) && v_s1 && !stall;
	assign finish_now = proc && finish;
	assign advance    = (state_q == S_SCAN) && rd_pend_q && !stall && !finish_now;
	assign emit       = (proc && need_emit) || ((state_q == S_FIN) && emit_ok);

	assign mem_we    = proc && wr;
	assign mem_waddr = idx_s1;
	assign mem_wdata = wentry;
	assign mem_re    = advance;
	assign mem_raddr = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_pend_q <= 1'b0;
			v_s1      <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			if (proc && st_wr) begin
				status_q[idx_s1] <= st_new;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_SCAN;
						cnt_q     <= '0;
						rd_pend_q <= 1'b1;
						v_s1      <= 1'b0;
					end
				end
				S_SCAN: begin
					if (finish_now) begin
						state_q   <= S_IDLE;
						rd_pend_q <= 1'b0;
						v_s1      <= 1'b0;
					end else begin
						if (advance) begin
							v_s1  <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == LAST_IDX) begin
								rd_pend_q <= 1'b0;
							end
						end else if (!stall) begin
							v_s1 <= 1'b0;
						end
						if (proc && (idx_s1 == LAST_IDX)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			ip_q    <= s_tdata[31:0];
			mac_q   <= s_tdata[79:32];
			delay_q <= s_tdata[95:80];
		end
		if (advance) begin
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_hit_q  <= e_hit;
			out_res_q  <= e_res;
			out_idx_q  <= (state_q == S_FIN) ? '0 : idx_ext[OUT_IDX_W-1:0];
			out_ip_q   <= (state_q == S_FIN) ? 32'd0 : e_ip;
			out_mac_q  <= e_mac;
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_mac_q, out_ip_q, out_idx_q, out_res_q, out_hit_q};

endmodule

>>> verif/arpc_checker.sv
`timescale 1ns / 100ps
// Checker for the ARP cache table: watches the input, result and register ports, keeps its
// own copy of the entry table and compares every result beat with the predicted one.
// Depends on arpc_pkg for the operation, status and result codes.
module arpc_checker
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          outstanding
);

	typedef struct packed {
		logic [2:0]  kind;
		logic        hit;
		logic        is_res;
		logic [4:0]  idx;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        last;
	} arp_result_t;

	logic [15:0] ttl_reload;
	logic [3:0]  retry_reload;
	logic [1:0]  tbl_status [ENTRIES];
	logic [31:0] tbl_ip [ENTRIES];
	logic [47:0] tbl_mac [ENTRIES];
	int          tbl_ttl [ENTRIES];
	int          tbl_retries [ENTRIES];
	arp_result_t expected_results [$];

	function automatic arp_result_t mk(logic [2:0] kind, logic hit, logic is_res,
			int idx, logic [31:0] ip, logic [47:0] mac, logic last);
		arp_result_t r;
		r.kind = kind;
		r.hit = hit;
		r.is_res = is_res;
		r.idx = idx[4:0];
		r.ip = ip;
		r.mac = mac;
		r.last = last;
		return r;
	endfunction

	task automatic claim_entry(logic [1:0] status, logic [31:0] ip, logic [47:0] mac);
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_status[i] == ST_FREE) begin
				tbl_status[i] = status;
				tbl_ip[i] = ip;
				tbl_mac[i] = mac;
				tbl_ttl[i] = ttl_reload;
				tbl_retries[i] = retry_reload;
				expected_results.push_back(mk(KIND_STORED, 0, 0, i, ip, '0, 1));
				return;
			end
		end
		expected_results.push_back(mk(KIND_FULL, 0, 0, 0, '0, '0, 1));
	endtask

	task automatic predict_operation(logic [1:0] op, logic [95:0] data);
		logic [31:0] ip;
		logic [47:0] mac;
		int          delay;
		ip = data[31:0];
		mac = data[79:32];
		delay = data[95:80];
		case (op)
			OP_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_status[i] != ST_FREE && tbl_ip[i] == ip) begin
						expected_results.push_back(mk(KIND_LOOKUP, 1,
							tbl_status[i] == ST_RESOLVED, i, tbl_ip[i], tbl_mac[i], 1));
						return;
					end
				end
				expected_results.push_back(mk(KIND_LOOKUP, 0, 0, 0, '0, '0, 1));
			end
			OP_INSERT: claim_entry(ST_RESOLVED, ip, mac);
			OP_ALLOC: claim_entry(ST_PENDING, ip, '0);
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_status[i] == ST_FREE)
						continue;
					tbl_ttl[i] -= delay;
					if (tbl_ttl[i] > 0)
						continue;
					if (tbl_status[i] == ST_PENDING) begin
						tbl_retries[i]--;
						if (tbl_retries[i] < 0) begin
							tbl_status[i] = ST_FREE;
							expected_results.push_back(mk(KIND_DROP, 0, 0, i, tbl_ip[i], '0, 0));
						end else begin
							tbl_ttl[i] = ttl_reload;
							expected_results.push_back(mk(KIND_RETRY, 0, 0, i, tbl_ip[i], '0, 0));
						end
					end else begin
						tbl_status[i] = ST_FREE;
					end
				end
				expected_results.push_back(mk(KIND_TICK, 0, 0, 0, '0, '0, 1));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		arp_result_t got;
		arp_result_t want;
		if (!arst_n) begin
			ttl_reload = 16'd600;
			retry_reload = 4'd4;
			for (int i = 0; i < ENTRIES; i++)
				tbl_status[i] = ST_FREE;
			expected_results.delete();
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_TIMEOUT)
					ttl_reload = pwdata[15:0];
				else
					retry_reload = pwdata[3:0];
			end
			if (s_tvalid && s_tready)
				predict_operation(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				got = mk(m_tuser, m_tdata[0], m_tdata[1], m_tdata[6:2], m_tdata[38:7],
					m_tdata[86:39], m_tlast);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_tdata[87] !== 1'b0) begin
						$display("%0t: result mismatch: expected kind %0d hit %0d res %0d idx %0d ip %h mac %h last %0d",
							$time, want.kind, want.hit, want.is_res, want.idx, want.ip,
							want.mac, want.last);
						$display("%0t:                  actual kind %0d hit %0d res %0d idx %0d ip %h mac %h last %0d",
							$time, got.kind, got.hit, got.is_res, got.idx, got.ip,
							got.mac, got.last);
						fails++;
					end
				end
			end
		end
		outstanding = expected_results.size();
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the ARP cache testbench: clock, reset, register writes and operation stimulus.
// Depends on arpc_pkg, the block and arpc_checker, which does all the predicting and checking.
module testbench;
	import arpc_pkg::*;

	localparam int ENTRIES = 32;
	localparam int LIMIT = 600000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_LOOKUP;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [87:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fails;
	int          outstanding;
	int          cycles = 0;
	bit          calm = 0;
	logic [31:0] ip_pool [8];

	arp_cache_table_with_aging_top #(.ENTRIES(ENTRIES)) dut (.*);

	arpc_checker #(.ENTRIES(ENTRIES)) u_chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// The receiver stalls at random, and is always ready in calm mode.
	always @(negedge clk) begin
		int stall;
		if (!arst_n || calm) begin
			m_tready <= arst_n;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall = $urandom_range(1, 6);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (ENTRIES + 20) @(negedge clk);
	endtask

	task automatic send_op(logic [1:0] op, logic [31:0] ip, logic [47:0] mac,
			logic [15:0] delay);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {delay, mac, ip};
		#1;
		while (!s_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	task automatic random_ops(int count, int max_delay);
		logic [1:0]  op;
		logic [15:0] delay;
		int          pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			op = pick < 3 ? OP_LOOKUP : pick < 5 ? OP_INSERT : pick < 7 ? OP_ALLOC : OP_TICK;
			delay = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, max_delay));
			send_op(op, $urandom_range(0, 7) == 0 ? $urandom : ip_pool[$urandom_range(0, 7)],
				{$urandom, $urandom}, delay);
			if (n == count / 2 && count > 40)
				drain();
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			ip_pool[i] = $urandom;
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send_op(OP_LOOKUP, 32'h0, '0, '0);
		send_op(OP_INSERT, 32'h0, 48'h0, '0);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		send_op(OP_ALLOC, 32'h1234_5678, 48'hFFFF_FFFF_FFFF, '0);
		send_op(OP_INSERT, 32'h0, 48'h1111_2222_3333, '0);
		send_op(OP_LOOKUP, 32'h0, '0, '0);
		send_op(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0);
		send_op(OP_LOOKUP, 32'h1234_5678, '0, '0);
		send_op(OP_LOOKUP, 32'h8765_4321, '0, '0);
		send_op(OP_TICK, '0, '0, 16'd0);
		send_op(OP_TICK, '0, '0, 16'd599);
		send_op(OP_TICK, '0, '0, 16'd1);
		send_op(OP_LOOKUP, 32'h0, '0, '0);
		for (int i = 0; i < 5; i++)
			send_op(OP_TICK, '0, '0, 16'hFFFF);
		send_op(OP_LOOKUP, 32'h1234_5678, '0, '0);
		drain();

		write_reg(REG_TIMEOUT, 32'd1);
		write_reg(REG_RETRY, 32'd0);
		random_ops(50, 3);
		drain();

		write_reg(REG_TIMEOUT, 32'd65535);
		write_reg(REG_RETRY, 32'd15);
		random_ops(60, 40);
		drain();

		write_reg(REG_TIMEOUT, 32'd40);
		write_reg(REG_RETRY, 32'd2);
		random_ops(35, 20);
		calm = 1;
		random_ops(25, 20);
		drain();

		if (fails == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
